### rtl/ppc_pkg.sv
// Shared types, widths and constants of the polygon plane clipper.
package ppc_pkg;

  localparam int unsigned AttrW      = 32;
  localparam int unsigned NumAttr    = 5;
  localparam int unsigned NrmW       = 16;
  localparam int unsigned DistW      = 50;
  localparam int unsigned DiffW      = DistW + 1;
  localparam int unsigned RemW       = DiffW + 1;
  localparam int unsigned FracW      = 16;
  localparam int unsigned TW         = FracW + 1;
  localparam int unsigned MulAW      = AttrW + 2;
  localparam int unsigned MulBW      = TW + 1;
  localparam int unsigned ProdW      = MulAW + MulBW;
  localparam int unsigned CountW     = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned MinPoly    = 3;
  localparam logic [NrmW-1:0] NormalZReset = 16'd16384;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NORMAL_X = 2'd0,
    CFG_NORMAL_Y = 2'd1,
    CFG_NORMAL_Z = 2'd2,
    CFG_PLANE_D  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIST,
    S_SEL,
    S_EDGE,
    S_EDGE2,
    S_DIV,
    S_MUL,
    S_ADD,
    S_EMITX,
    S_EDGE_END,
    S_END
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### rtl/polygon_plane_clip.sv
// Top level of the polygon plane clipper: sequencer, vertex storage and output register.
//
// Clips a streamed polygon against the plane normal . p >= plane_distance. Vertices
// arrive one per transaction; each one is held while the block works on it. Each edge
// that crosses the plane runs the 16-step divider, then the five interpolations
// through the one shared multiplier and the emit; the divider finishes at once
// when the far end lies exactly on the plane. A last vertex also closes the polygon
// and emits the end-of-polygon transaction. Output stalls hold the block longer.
module polygon_plane_clip #(
  parameter int unsigned MAX_VERTICES = ppc_pkg::MaxVerticesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ppc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ppc_pkg::DistW-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [31:0]               pos_x_i,
  input  logic signed [31:0]               pos_y_i,
  input  logic signed [31:0]               pos_z_i,
  input  logic signed [31:0]               tex_u_i,
  input  logic signed [31:0]               tex_v_i,
  input  logic                             last_vertex_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             item_kind_o,
  output logic signed [31:0]               out_x_o,
  output logic signed [31:0]               out_y_o,
  output logic signed [31:0]               out_z_o,
  output logic signed [31:0]               out_u_o,
  output logic signed [31:0]               out_v_o,
  output logic                             from_intersection_o,
  output logic                             last_result_o,
  output logic [7:0]                       vertex_count_o,
  output logic                             polygon_ok_o,
  output logic                             crossed_o
);

  localparam int unsigned CntMax = 2 * MAX_VERTICES;
  localparam int unsigned CntW   = $clog2(CntMax + 1);
  localparam int unsigned AW     = ppc_pkg::AttrW;
  localparam int unsigned NA     = ppc_pkg::NumAttr;

  ppc_pkg::state_e state_q, state_d;

  logic signed [ppc_pkg::NrmW-1:0]  nrm_q [3];
  logic signed [ppc_pkg::DistW-1:0] pd_q;

  logic signed [AW-1:0] cur_q   [NA];
  logic signed [AW-1:0] prev_q  [NA];
  logic signed [AW-1:0] first_q [NA];
  logic signed [AW-1:0] itp_q   [NA];
  logic signed [ppc_pkg::DistW-1:0] acc_q, prev_dist_q, first_dist_q;
  logic last_q, mode_q, await_q, cross_q;
  logic [CntW-1:0] cnt_q;
  logic [2:0] k_q;
  logic [ppc_pkg::TW-1:0] t_q;

  logic out_valid_q, kind_q, fi_q, lr_q, ok_q, cr_q;
  logic signed [AW-1:0] ov_q [NA];
  logic [7:0] vc_q;

  logic free, in_acc;
  logic signed [ppc_pkg::DistW-1:0] da, db;
  logic ina, inb;
  logic signed [ppc_pkg::DiffW-1:0] num_s, den_s;
  logic [ppc_pkg::DiffW-1:0] num_a, den_a, div_num, div_den;
  logic div_start;
  ppc_pkg::div_sts_t div_sts;
  logic [ppc_pkg::TW-1:0] div_q;
  logic signed [ppc_pkg::MulAW-1:0] mul_a;
  logic signed [ppc_pkg::MulBW-1:0] mul_b;
  logic signed [ppc_pkg::ProdW-1:0] prod;
  logic signed [AW-1:0] vb;
  logic signed [ppc_pkg::ProdW-1:0] prod_sh;
  logic emit_a, emit_x, emit_end;

  assign free   = !out_valid_q || !out_stall_i;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ppc_pkg::S_IDLE);

  assign da  = prev_dist_q;
  assign db  = mode_q ? first_dist_q : acc_q;
  assign ina = da >= pd_q;
  assign inb = db >= pd_q;
  assign num_s = ppc_pkg::DiffW'(pd_q) - ppc_pkg::DiffW'(da);
  assign den_s = ppc_pkg::DiffW'(db) - ppc_pkg::DiffW'(da);
  assign num_a = num_s[ppc_pkg::DiffW-1] ? ppc_pkg::DiffW'(-num_s) : num_s;
  assign den_a = den_s[ppc_pkg::DiffW-1] ? ppc_pkg::DiffW'(-den_s) : den_s;
  assign div_num = num_a;
  assign div_den = den_a;

  assign vb = mode_q ? first_q[k_q] : cur_q[k_q];

  always_comb begin
    if (state_q == ppc_pkg::S_DIST) begin
      mul_a = ppc_pkg::MulAW'(cur_q[k_q[1:0]]);
      mul_b = ppc_pkg::MulBW'(nrm_q[k_q[1:0]]);
    end else begin
      mul_a = ppc_pkg::MulAW'(vb) - ppc_pkg::MulAW'(prev_q[k_q]);
      mul_b = $signed({1'b0, t_q});
    end
  end

  ppc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  ppc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .sts_o   (div_sts),
    .q_o     (div_q)
  );

  assign prod_sh = prod >>> ppc_pkg::FracW;

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    emit_a    = 1'b0;
    emit_x    = 1'b0;
    emit_end  = 1'b0;
    unique case (state_q)
      ppc_pkg::S_IDLE: if (in_acc) state_d = ppc_pkg::S_DIST;
      ppc_pkg::S_DIST: if (k_q == 3'd3) state_d = ppc_pkg::S_SEL;
      ppc_pkg::S_SEL: state_d = await_q ? ppc_pkg::S_EDGE_END : ppc_pkg::S_EDGE;
      ppc_pkg::S_EDGE: begin
        if (!ina) begin
          state_d = ppc_pkg::S_EDGE2;
        end else if (free) begin
          emit_a  = 1'b1;
          state_d = ppc_pkg::S_EDGE2;
        end
      end
      ppc_pkg::S_EDGE2: begin
        if (ina != inb) begin
          div_start = 1'b1;
          state_d   = ppc_pkg::S_DIV;
        end else begin
          state_d = ppc_pkg::S_EDGE_END;
        end
      end
      ppc_pkg::S_DIV: if (div_sts.done) state_d = ppc_pkg::S_MUL;
      ppc_pkg::S_MUL: state_d = ppc_pkg::S_ADD;
      ppc_pkg::S_ADD: state_d = (k_q == 3'(NA - 1)) ? ppc_pkg::S_EMITX : ppc_pkg::S_MUL;
      ppc_pkg::S_EMITX: begin
        if (free) begin
          emit_x  = 1'b1;
          state_d = ppc_pkg::S_EDGE_END;
        end
      end
      ppc_pkg::S_EDGE_END: begin
        if (mode_q) state_d = ppc_pkg::S_END;
        else if (last_q) state_d = ppc_pkg::S_EDGE;
        else state_d = ppc_pkg::S_IDLE;
      end
      ppc_pkg::S_END: begin
        if (free) begin
          emit_end = 1'b1;
          state_d  = ppc_pkg::S_IDLE;
        end
      end
      default: state_d = ppc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppc_pkg::S_IDLE;
      nrm_q[0]    <= '0;
      nrm_q[1]    <= '0;
      nrm_q[2]    <= ppc_pkg::NormalZReset;
      pd_q        <= '0;
      await_q     <= 1'b1;
      cross_q     <= 1'b0;
      cnt_q       <= '0;
      mode_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (ppc_pkg::cfg_idx_e'(cfg_idx_i))
          ppc_pkg::CFG_NORMAL_X: nrm_q[0] <= cfg_data_i[ppc_pkg::NrmW-1:0];
          ppc_pkg::CFG_NORMAL_Y: nrm_q[1] <= cfg_data_i[ppc_pkg::NrmW-1:0];
          ppc_pkg::CFG_NORMAL_Z: nrm_q[2] <= cfg_data_i[ppc_pkg::NrmW-1:0];
          ppc_pkg::CFG_PLANE_D:  pd_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (emit_a || emit_x || emit_end) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if ((emit_a || emit_x) && (cnt_q < CntW'(CntMax))) cnt_q <= cnt_q + 1'b1;
      if (emit_x) cross_q <= 1'b1;
      unique case (state_q)
        ppc_pkg::S_IDLE: begin
          k_q    <= '0;
          mode_q <= 1'b0;
        end
        ppc_pkg::S_DIST: k_q <= (k_q == 3'd3) ? 3'd0 : k_q + 3'd1;
        ppc_pkg::S_SEL: begin
          if (await_q) begin
            await_q <= 1'b0;
            cnt_q   <= '0;
            cross_q <= 1'b0;
          end
        end
        ppc_pkg::S_DIV: k_q <= '0;
        ppc_pkg::S_ADD: k_q <= k_q + 3'd1;
        ppc_pkg::S_EDGE_END: if (!mode_q && last_q) mode_q <= 1'b1;
        ppc_pkg::S_END: begin
          if (emit_end) begin
            await_q <= 1'b1;
            cnt_q   <= '0;
            cross_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q[0] <= pos_x_i;
      cur_q[1] <= pos_y_i;
      cur_q[2] <= pos_z_i;
      cur_q[3] <= tex_u_i;
      cur_q[4] <= tex_v_i;
      last_q   <= last_vertex_i;
      acc_q    <= '0;
    end
    if (state_q == ppc_pkg::S_DIST && k_q != 3'd0) begin
      acc_q <= acc_q + ppc_pkg::DistW'(prod);
    end
    if (state_q == ppc_pkg::S_SEL && await_q) begin
      first_q      <= cur_q;
      first_dist_q <= acc_q;
    end
    if (state_q == ppc_pkg::S_EDGE_END && !mode_q) begin
      prev_q      <= cur_q;
      prev_dist_q <= acc_q;
    end
    if (div_sts.done) t_q <= div_q;
    if (state_q == ppc_pkg::S_ADD) begin
      itp_q[k_q] <= prev_q[k_q] + AW'(prod_sh);
    end
    if (emit_a || emit_x) begin
      kind_q <= 1'b0;
      fi_q   <= emit_x;
      lr_q   <= 1'b0;
      vc_q   <= '0;
      ok_q   <= 1'b0;
      cr_q   <= 1'b0;
      for (int i = 0; i < NA; i++) ov_q[i] <= emit_x ? itp_q[i] : prev_q[i];
    end else if (emit_end) begin
      kind_q <= 1'b1;
      fi_q   <= 1'b0;
      lr_q   <= 1'b1;
      vc_q   <= 8'(cnt_q);
      ok_q   <= (cnt_q >= CntW'(ppc_pkg::MinPoly));
      cr_q   <= cross_q;
      for (int i = 0; i < NA; i++) ov_q[i] <= '0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign item_kind_o         = kind_q;
  assign out_x_o             = ov_q[0];
  assign out_y_o             = ov_q[1];
  assign out_z_o             = ov_q[2];
  assign out_u_o             = ov_q[3];
  assign out_v_o             = ov_q[4];
  assign from_intersection_o = fi_q;
  assign last_result_o       = lr_q;
  assign vertex_count_o      = vc_q;
  assign polygon_ok_o        = ok_q;
  assign crossed_o           = cr_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CntMax)) else $error("vertex count above saturation");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ppc_pkg::S_IDLE |-> !div_sts.busy) else $error("divider busy while idle");
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_sts.busy) else $error("divider restarted while busy");
  a_cross_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_x |=> cross_q) else $error("crossing not recorded");

endmodule

### rtl/ppc_div.sv
// Iterative restoring divider producing a Q1.16 ratio, one quotient bit per cycle.
module ppc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ppc_pkg::DiffW-1:0]       num_i,
  input  logic [ppc_pkg::DiffW-1:0]       den_i,
  output ppc_pkg::div_sts_t               sts_o,
  output logic [ppc_pkg::TW-1:0]          q_o
);

  logic                          busy_q, done_q;
  logic [ppc_pkg::RemW-1:0]      r_q;
  logic [ppc_pkg::DiffW-1:0]     den_q;
  logic [ppc_pkg::TW-1:0]        q_q;
  logic [4:0]                    n_q;
  logic [ppc_pkg::RemW-1:0]      r_sh;
  logic                          ge;

  assign r_sh = {r_q[ppc_pkg::RemW-2:0], 1'b0};
  assign ge   = r_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      n_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (num_i >= den_i) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          n_q    <= 5'(ppc_pkg::FracW);
        end
      end else if (busy_q) begin
        n_q <= n_q - 5'd1;
        if (n_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= {1'b0, num_i};
      den_q <= den_i;
      q_q   <= (num_i >= den_i) ? ppc_pkg::TW'(1 << ppc_pkg::FracW) : '0;
    end else if (busy_q) begin
      r_q <= ge ? (r_sh - {1'b0, den_q}) : r_sh;
      q_q <= {q_q[ppc_pkg::TW-2:0], ge};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign q_o        = q_q;

endmodule

### rtl/ppc_mul.sv
// Shared signed multiplier with a registered product.
module ppc_mul (
  input  logic                              clk_i,
  input  logic signed [ppc_pkg::MulAW-1:0]  a_i,
  input  logic signed [ppc_pkg::MulBW-1:0]  b_i,
  output logic signed [ppc_pkg::ProdW-1:0]  p_o
);

  logic signed [ppc_pkg::ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

### bench/ppc_checker.sv
// Checker for the polygon plane clipper: predicts every result transaction and compares it.
module ppc_checker
  import ppc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [DistW-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic signed [31:0]  tex_u_i,
  input  logic signed [31:0]  tex_v_i,
  input  logic                last_vertex_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                item_kind_i,
  input  logic [31:0]         out_x_i,
  input  logic [31:0]         out_y_i,
  input  logic [31:0]         out_z_i,
  input  logic [31:0]         out_u_i,
  input  logic [31:0]         out_v_i,
  input  logic                from_intersection_i,
  input  logic                last_result_i,
  input  logic [7:0]          vertex_count_i,
  input  logic                polygon_ok_i,
  input  logic                crossed_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KindVertex = 1'b0;
  localparam logic KindEnd    = 1'b1;
  localparam int unsigned CountMax = 2 * MAX_VERTICES;

  typedef longint attr_vec_t [NumAttr];

  typedef struct {
    logic        kind;
    logic [31:0] attr [NumAttr];
    logic        inter;
    logic        last;
    logic [7:0]  count;
    logic        ok;
    logic        crossed;
  } clip_item_t;

  clip_item_t clipped_q[$];

  logic signed [NrmW-1:0]  nrm_x, nrm_y, nrm_z;
  logic signed [DistW-1:0] plane_d;
  attr_vec_t   first_v, prev_v;
  longint      first_d, prev_d;
  bit          awaiting, crossing;
  int unsigned emitted;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = clipped_q.size();

  function automatic longint q16_ratio(longint unsigned num, longint unsigned den);
    longint unsigned r;
    longint q;
    r = num;
    q = 0;
    if (den == 0 || num >= den) return 65536;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  task automatic push_vertex(input attr_vec_t v, input bit inter);
    clip_item_t it;
    it.kind = KindVertex;
    for (int i = 0; i < NumAttr; i++) it.attr[i] = v[i][31:0];
    it.inter = inter;
    it.last = 1'b0;
    it.count = '0;
    it.ok = 1'b0;
    it.crossed = 1'b0;
    clipped_q.push_back(it);
    if (emitted < CountMax) emitted++;
  endtask

  task automatic clip_edge(input attr_vec_t a, input longint da, input attr_vec_t b,
                           input longint db);
    longint p, num, den, t;
    longint unsigned un, ud;
    attr_vec_t w;
    bit ina, inb;
    p = longint'(plane_d);
    ina = da >= p;
    inb = db >= p;
    if (ina) push_vertex(a, 1'b0);
    if (ina != inb) begin
      num = p - da;
      den = db - da;
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      t = q16_ratio(un, ud);
      for (int i = 0; i < NumAttr; i++) w[i] = a[i] + (((b[i] - a[i]) * t) >>> 16);
      push_vertex(w, 1'b1);
      crossing = 1'b1;
    end
  endtask

  task automatic clip_vertex(input attr_vec_t cur, input bit last);
    longint d;
    clip_item_t it;
    d = longint'(nrm_x) * cur[0] + longint'(nrm_y) * cur[1] + longint'(nrm_z) * cur[2];
    if (awaiting) begin
      first_v = cur;
      first_d = d;
      awaiting = 1'b0;
      emitted = 0;
      crossing = 1'b0;
    end else begin
      clip_edge(prev_v, prev_d, cur, d);
    end
    prev_v = cur;
    prev_d = d;
    if (last) begin
      clip_edge(prev_v, prev_d, first_v, first_d);
      it.kind = KindEnd;
      for (int i = 0; i < NumAttr; i++) it.attr[i] = '0;
      it.inter = 1'b0;
      it.last = 1'b1;
      it.count = emitted[7:0];
      it.ok = emitted >= MinPoly;
      it.crossed = crossing;
      clipped_q.push_back(it);
      awaiting = 1'b1;
      emitted = 0;
      crossing = 1'b0;
      prev_d = 0;
      first_d = 0;
    end
  endtask

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp, act);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    attr_vec_t cur;
    clip_item_t exp;
    if (!rst_ni) begin
      nrm_x <= '0;
      nrm_y <= '0;
      nrm_z <= NormalZReset;
      plane_d <= '0;
      awaiting = 1'b1;
      emitted = 0;
      crossing = 1'b0;
      prev_d = 0;
      first_d = 0;
      clipped_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (clipped_q.size() == 0) begin
          $error("Result transaction with no expected result pending");
          fails++;
        end else begin
          exp = clipped_q.pop_front();
          check_field("item_kind", exp.kind, item_kind_i);
          check_field("out_x", exp.attr[0], out_x_i);
          check_field("out_y", exp.attr[1], out_y_i);
          check_field("out_z", exp.attr[2], out_z_i);
          check_field("out_u", exp.attr[3], out_u_i);
          check_field("out_v", exp.attr[4], out_v_i);
          check_field("from_intersection", exp.inter, from_intersection_i);
          check_field("last_result", exp.last, last_result_i);
          check_field("vertex_count", exp.count, vertex_count_i);
          check_field("polygon_ok", exp.ok, polygon_ok_i);
          check_field("crossed", exp.crossed, crossed_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        cur[0] = longint'(pos_x_i);
        cur[1] = longint'(pos_y_i);
        cur[2] = longint'(pos_z_i);
        cur[3] = longint'(tex_u_i);
        cur[4] = longint'(tex_v_i);
        clip_vertex(cur, last_vertex_i);
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_NORMAL_X: nrm_x <= cfg_data_i[NrmW-1:0];
          CFG_NORMAL_Y: nrm_y <= cfg_data_i[NrmW-1:0];
          CFG_NORMAL_Z: nrm_z <= cfg_data_i[NrmW-1:0];
          default:      plane_d <= cfg_data_i;
        endcase
      end
    end
  end

  initial fails = 0;

endmodule

### bench/tb_polygon_plane_clip.sv
// Testbench top of the polygon plane clipper: clock, reset, stimulus and verdict.
module tb_polygon_plane_clip;
  timeunit 1ns;
  timeprecision 1ps;
  import ppc_pkg::*;

  logic clk, rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [DistW-1:0] cfg_data;
  logic in_valid, in_stall;
  logic signed [31:0] pos_x, pos_y, pos_z, tex_u, tex_v;
  logic last_vertex;
  logic out_valid, out_stall;
  logic item_kind, from_intersection, last_result, polygon_ok, crossed;
  logic signed [31:0] out_x, out_y, out_z, out_u, out_v;
  logic [7:0] vertex_count;
  int fail_count, pending;
  int gap_pct, stall_pct;
  bit quiet;

  polygon_plane_clip i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .tex_u_i(tex_u), .tex_v_i(tex_v), .last_vertex_i(last_vertex),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .item_kind_o(item_kind), .out_x_o(out_x), .out_y_o(out_y), .out_z_o(out_z),
    .out_u_o(out_u), .out_v_o(out_v), .from_intersection_o(from_intersection),
    .last_result_o(last_result), .vertex_count_o(vertex_count),
    .polygon_ok_o(polygon_ok), .crossed_o(crossed)
  );

  ppc_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .tex_u_i(tex_u), .tex_v_i(tex_v), .last_vertex_i(last_vertex),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .item_kind_i(item_kind), .out_x_i(out_x), .out_y_i(out_y), .out_z_i(out_z),
    .out_u_i(out_u), .out_v_i(out_v), .from_intersection_i(from_intersection),
    .last_result_i(last_result), .vertex_count_i(vertex_count),
    .polygon_ok_i(polygon_ok), .crossed_i(crossed),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_vertex(input logic [31:0] x, y, z, u, v, input logic last);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    tex_u <= u;
    tex_v <= v;
    last_vertex <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [DistW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic set_plane(input logic [15:0] nx, ny, nz, input logic [DistW-1:0] pd);
    cfg_write(CFG_NORMAL_X, {{(DistW-16){nx[15]}}, nx});
    cfg_write(CFG_NORMAL_Y, {{(DistW-16){ny[15]}}, ny});
    cfg_write(CFG_NORMAL_Z, {{(DistW-16){nz[15]}}, nz});
    cfg_write(CFG_PLANE_D, pd);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
  endfunction

  function automatic logic [DistW-1:0] rand_dist();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return '0;
      1: return DistW'($signed(r[40:0]));
      2: return DistW'($signed(r[34:0]));
      default: return r[DistW-1:0];
    endcase
  endfunction

  task automatic random_polygons(input int n_items);
    int left, sides;
    left = n_items;
    while (left > 0) begin
      sides = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 7);
      if (sides > left) sides = left;
      for (int i = 0; i < sides; i++)
        send_vertex(rand_coord(), rand_coord(), rand_coord(), $urandom, $urandom,
                    i == sides - 1);
      left -= sides;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_NORMAL_X;
    cfg_data <= '0;
    in_valid <= 1'b0;
    pos_x <= '0;
    pos_y <= '0;
    pos_z <= '0;
    tex_u <= '0;
    tex_v <= '0;
    last_vertex <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    send_vertex(32'd5, 32'd6, 32'd65536, 32'd7, 32'd8, 1'b1);
    send_vertex(32'd5, 32'd6, -32'sd1, 32'd7, 32'd8, 1'b1);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0);
    send_vertex(32'h80000000, 32'h7fffffff, 32'd0, 32'h80000000, 32'h7fffffff, 1'b0);
    send_vertex(32'd0, 32'd0, 32'd1, 32'hffffffff, 32'd0, 1'b1);
    send_vertex(32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 1'b0);
    send_vertex(32'd65536, 32'd0, -32'sd65536, 32'd65536, 32'd131072, 1'b0);
    send_vertex(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1);
    send_vertex(32'd1, 32'd1, -32'sd5, 32'd1, 32'd1, 1'b0);
    send_vertex(32'd2, 32'd2, 32'h80000000, 32'd2, 32'd2, 1'b0);
    send_vertex(32'd3, 32'd3, -32'sd1, 32'd3, 32'd3, 1'b1);
    send_vertex(32'd0, 32'd0, 32'd0, 32'd10, 32'd20, 1'b0);
    send_vertex(32'd0, 32'd0, -32'sd1, 32'd30, 32'd40, 1'b0);
    send_vertex(32'd9, 32'd9, 32'd0, 32'd50, 32'd60, 1'b0);
    send_vertex(32'd9, 32'd9, -32'sd3, 32'd70, 32'd80, 1'b1);
    // The plane moves while a polygon is half sent.
    send_vertex(32'd4, 32'd4, 32'd100, 32'd4, 32'd4, 1'b0);
    send_vertex(32'd8, 32'd8, -32'sd100, 32'd8, 32'd8, 1'b0);
    drain();
    set_plane(16'd0, 16'd0, 16'd16384, -50'sd4000000);
    send_vertex(32'd6, 32'd6, 32'd50, 32'd6, 32'd6, 1'b1);
    drain();

    gap_pct = 30;
    stall_pct = 20;
    set_plane(16'h8000, 16'h8000, 16'h8000, 50'h2000000000000);
    random_polygons(30);
    drain();
    set_plane(16'h7fff, 16'h7fff, 16'h7fff, 50'h1ffffffffffff);
    random_polygons(20);
    drain();

    // Alternating sides push the emitted count past its saturation point.
    set_plane(16'd0, 16'd0, 16'd16384, '0);
    for (int i = 0; i < 90; i++)
      send_vertex($urandom, $urandom, (i % 2 == 0) ? 32'd65536 : -32'sd65536,
                  $urandom, $urandom, i == 89);
    drain();

    for (int ph = 0; ph < 2; ph++) begin
      gap_pct = $urandom_range(0, 50);
      stall_pct = $urandom_range(0, 40);
      set_plane(16'($urandom), 16'($urandom), 16'($urandom), rand_dist());
      random_polygons(20);
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
      random_polygons(15);
      drain();
    end

    quiet = 1'b1;
    set_plane(16'($urandom), 16'($urandom), 16'($urandom), rand_dist());
    random_polygons(40);
    drain();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### polygon_plane_clip.f
rtl/ppc_pkg.sv
rtl/ppc_div.sv
rtl/ppc_mul.sv
rtl/polygon_plane_clip.sv
bench/ppc_checker.sv
bench/tb_polygon_plane_clip.sv
